// ===== hdl/wsd_pkg.sv =====
package wsd_pkg;

  // Operation codes carried by action
  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_STEAL = 2'd2,
    ACT_NOP   = 2'd3
  } action_e;

  localparam int unsigned ActionW = 2;
  localparam int unsigned TaskW   = 64;

  // Per-transaction decisions from the pointer control to the rest of the block
  typedef struct packed {
    logic wr_en;     // store the incoming handle
    logic rd_en;     // fetch a handle from the store
    logic found;     // pop or steal hit a non-empty deque
    logic overflow;  // push dropped, deque full
  } wsd_op_t;

endpackage

// ===== hdl/wsd_store.sv =====
module wsd_store #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned SlotW = $clog2(DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    wr_en_i,
  input  logic                    rd_en_i,
  input  logic [SlotW-1:0]        addr_i,
  input  logic [wsd_pkg::TaskW-1:0] wr_data_i,
  output logic [wsd_pkg::TaskW-1:0] rd_data_o
);
  import wsd_pkg::*;

  logic [TaskW-1:0] mem_q [DEPTH];
  logic [TaskW-1:0] rd_data_q;

  // single port: one write or one read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[addr_i] <= wr_data_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/wsd_ctrl.sv =====
module wsd_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned SlotW = $clog2(DEPTH),
  localparam int unsigned CntW  = $clog2(DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [wsd_pkg::ActionW-1:0]  action_i,
  output wsd_pkg::wsd_op_t             op_o,
  output logic [SlotW-1:0]             slot_o,
  output logic [CntW-1:0]              count_o
);
  import wsd_pkg::*;

  localparam logic [SlotW-1:0] SlotLast = SlotW'(DEPTH - 1);
  localparam logic [CntW-1:0]  CntFull  = CntW'(DEPTH);

  logic [SlotW-1:0] head_q, head_d;
  logic [SlotW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SlotW-1:0] head_inc, tail_inc, tail_dec;
  logic             empty, full;
  action_e          act;

  assign act      = action_e'(action_i);
  assign empty    = (count_q == '0);
  assign full     = (count_q == CntFull);
  assign head_inc = (head_q == SlotLast) ? '0 : head_q + SlotW'(1);
  assign tail_inc = (tail_q == SlotLast) ? '0 : tail_q + SlotW'(1);
  assign tail_dec = (tail_q == '0) ? SlotLast : tail_q - SlotW'(1);

  always_comb begin
    op_o    = '0;
    slot_o  = tail_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (accept_i) begin
      unique case (act)
        ACT_PUSH: begin
          if (full) begin
            op_o.overflow = 1'b1;
          end else begin
            op_o.wr_en = 1'b1;
            tail_d     = tail_inc;
            count_d    = count_q + CntW'(1);
          end
        end
        ACT_POP: begin
          slot_o = tail_dec;
          if (!empty) begin
            op_o.rd_en = 1'b1;
            op_o.found = 1'b1;
            tail_d     = tail_dec;
            count_d    = count_q - CntW'(1);
          end
        end
        ACT_STEAL: begin
          slot_o = head_q;
          if (!empty) begin
            op_o.rd_en = 1'b1;
            op_o.found = 1'b1;
            head_d     = head_inc;
            count_d    = count_q - CntW'(1);
          end
        end
        default: begin
          op_o = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // count only changes with an accepted transaction, so it tracks the result
  assign count_o = count_q;

endmodule

// ===== hdl/work_stealing_task_deque.sv =====
// The result of a transaction is presented in the cycle after it is accepted.
// Throughput: 1 transaction per cycle when not stalled; each uses the single store
// port at most once (push writes, pop/steal reads) and updates head/tail/count.
// Reset: async active low; clears head, tail, count and output valid. Store
// contents are not cleared; a slot is only read after a push has written it.
module work_stealing_task_deque #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wsd_pkg::ActionW-1:0]   action_i,
  input  logic [wsd_pkg::TaskW-1:0]     task_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [wsd_pkg::TaskW-1:0]     task_out_o,
  output logic                          overflow_o,
  output logic [CntW-1:0]               occupancy_o
);
  import wsd_pkg::*;

  localparam int unsigned SlotW = $clog2(DEPTH);

  logic             accept;
  wsd_op_t          op;
  logic [SlotW-1:0] slot;
  logic [TaskW-1:0] rd_data;
  logic             out_valid_q, out_valid_d;
  logic             found_q, overflow_q;

  // The result register frees up when it is empty or being taken this cycle,
  // so a new transaction can enter every cycle while the consumer keeps up.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Pointer/count control: decides the store access and the flags.
  wsd_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (action_i),
    .op_o     (op),
    .slot_o   (slot),
    .count_o  (occupancy_o)
  );

  // Handle storage: registered read data lines up with the result register.
  // A push followed directly by a pop of the same slot reads the new value,
  // since the write lands at an earlier edge than the read.
  wsd_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (op.wr_en),
    .rd_en_i   (op.rd_en),
    .addr_i    (slot),
    .wr_data_i (task_in_i),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      overflow_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        found_q    <= op.found;
        overflow_q <= op.overflow;
      end
    end
  end

  // Read data only moves on a store read, which only happens on accept,
  // so it holds steady while the result is stalled.
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign overflow_o  = overflow_q;
  assign task_out_o  = found_q ? rd_data : '0;

endmodule

// ===== bench/work_stealing_task_deque_test.sv =====
module work_stealing_task_deque_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int unsigned DEPTH    = 64;
  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned SlotW    = $clog2(DEPTH);
  // positions run modulo 2*DEPTH so full and empty differ
  localparam int unsigned PtrW     = $clog2(2 * DEPTH);
  localparam int          PERIOD   = 12;
  localparam int          MAX_GAP  = 12;
  localparam int          N_RANDOM = 1200;
  // long receiver hold-off: starts once this many results are in
  localparam int          HOLD_AT  = 300;
  localparam int          HOLD_LEN = 400;
  // worst case per item is a full sender gap plus a full receiver stall
  localparam int          LIMIT    = 400000;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_e;

  typedef struct {
    action_e          op;
    logic [TaskW-1:0] handle;
    int               gap;      // idle cycles before the item is offered
  } request_t;

  typedef struct {
    logic             found;
    logic [TaskW-1:0] handle;
    logic             overflow;
    logic [CntW-1:0]  held;
  } reply_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [ActionW-1:0]  action_i    = ACT_NOP;
  logic [TaskW-1:0]    task_in_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                found_o;
  logic [TaskW-1:0]    task_out_o;
  logic                overflow_o;
  logic [CntW-1:0]     occupancy_o;

  work_stealing_task_deque #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .task_in_i  (task_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .found_o    (found_o),
    .task_out_o (task_out_o),
    .overflow_o (overflow_o),
    .occupancy_o(occupancy_o)
  );

  // ---------------------------------------------------------------------------
  // Clock and the single reset pulse
  // ---------------------------------------------------------------------------
  initial begin
    forever #(PERIOD / 2) clk_i = ~clk_i;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    #3 rst_ni = 1'b1;          // away from both edges
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: ring of handles plus head/tail positions
  // ---------------------------------------------------------------------------
  logic [TaskW-1:0] ring_model [DEPTH];
  logic [PtrW-1:0]  head_pos = '0;
  logic [PtrW-1:0]  tail_pos = '0;

  request_t request_queue[$];
  reply_t   expected_replies[$];

  int  cycle_cnt = 0;
  int  req_cnt   = 0;
  int  rsp_cnt   = 0;
  int  req_total = 0;
  int  err_cnt   = 0;
  bit  req_taken = 1'b0;   // request transaction at the last rising edge
  bit  rsp_taken = 1'b0;   // result transaction at the last rising edge

  // Applies one operation to the shadow deque and returns the reply it gives.
  function automatic reply_t deque_apply(action_e op, logic [TaskW-1:0] handle);
    reply_t          r;
    logic [PtrW-1:0] count;
    r     = '{found: 1'b0, handle: '0, overflow: 1'b0, held: '0};
    count = tail_pos - head_pos;
    case (op)
      ACT_PUSH: begin
        if (count >= PtrW'(DEPTH)) begin
          r.overflow = 1'b1;               // full: handle dropped
        end else begin
          ring_model[SlotW'(tail_pos % DEPTH)] = handle;
          tail_pos = tail_pos + PtrW'(1);
        end
      end
      ACT_POP: begin
        if (count != '0) begin
          tail_pos = tail_pos - PtrW'(1);  // newest end
          r.handle = ring_model[SlotW'(tail_pos % DEPTH)];
          r.found  = 1'b1;
        end
      end
      ACT_STEAL: begin
        if (count != '0) begin
          r.handle = ring_model[SlotW'(head_pos % DEPTH)];   // oldest end
          head_pos = head_pos + PtrW'(1);
          r.found  = 1'b1;
        end
      end
      default: ;                           // unused code: no change
    endcase
    r.held = CntW'(tail_pos - head_pos);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Rising edge: check the result transaction, then predict the request one.
  // A result can never belong to a request taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    reply_t exp_r;
    if (!rst_ni) begin
      req_taken = 1'b0;
      rsp_taken = 1'b0;
    end else begin
      cycle_cnt++;
      rsp_taken = out_valid_o && !out_stall_i;
      if (rsp_taken) begin
        rsp_cnt++;
        if (expected_replies.size() == 0) begin
          $error("unexpected result: found %0d task_out %h overflow %0d occupancy %0d",
                 found_o, task_out_o, overflow_o, occupancy_o);
          err_cnt++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (found_o !== exp_r.found) begin
            $error("found: expected %0d, got %0d", exp_r.found, found_o);
            err_cnt++;
          end
          if (task_out_o !== exp_r.handle) begin
            $error("task_out: expected %h, got %h", exp_r.handle, task_out_o);
            err_cnt++;
          end
          if (overflow_o !== exp_r.overflow) begin
            $error("overflow: expected %0d, got %0d", exp_r.overflow, overflow_o);
            err_cnt++;
          end
          if (occupancy_o !== exp_r.held) begin
            $error("occupancy: expected %0d, got %0d", exp_r.held, occupancy_o);
            err_cnt++;
          end
        end
      end
      req_taken = in_valid_i && !in_stall_o;
      if (req_taken) begin
        expected_replies.push_back(deque_apply(action_e'(action_i), task_in_i));
        req_cnt++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: falling edge. Holds the payload while stalled, idles for the
  // item's gap once the previous transaction went through.
  // ---------------------------------------------------------------------------
  int idle_cnt = 0;

  always @(negedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || req_taken) begin
      if (request_queue.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (idle_cnt < request_queue[0].gap) begin
        idle_cnt++;
        in_valid_i <= 1'b0;
      end else begin
        nxt        = request_queue.pop_front();
        idle_cnt   = 0;
        in_valid_i <= 1'b1;
        action_i   <= nxt.op;
        task_in_i  <= nxt.handle;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: falling edge. Draws a stall per result; one long hold-off
  // lets the block back up into its input while the driver keeps offering.
  // Every third block of 150 results draws no per-result stalls.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(negedge clk_i) begin
    int w;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!hold_done && rsp_cnt >= HOLD_AT) begin
      hold_done   = 1'b1;
      hold_left   = HOLD_LEN - 1;
      out_stall_i <= 1'b1;
    end else if (rsp_taken) begin
      w = (((rsp_cnt / 150) % 3) == 2) ? 0 : $urandom_range(0, MAX_GAP);
      if (w > 0) begin
        stall_left  = w - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  initial begin
    while (cycle_cnt < LIMIT) @(posedge clk_i);
    $display("work_stealing_task_deque_test: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  task automatic queue_op(action_e op, logic [TaskW-1:0] handle, int gap);
    request_queue.push_back('{op: op, handle: handle, gap: gap});
    req_total++;
  endtask

  function automatic logic [TaskW-1:0] rand_handle();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  initial begin
    phase_e  ph;
    int      len;
    int      push_pct;
    int      roll;
    int      gap;
    int      real_ops;
    bit      bursty;
    action_e op;

    // Directed: empty-deque removals, unused code, handle extremes,
    // both removal ends, then drain back past empty.
    queue_op(ACT_STEAL, {$urandom, $urandom}, 0);
    queue_op(ACT_POP,   {$urandom, $urandom}, 0);
    queue_op(ACT_NOP,   '1, 0);
    queue_op(ACT_PUSH,  '0, 0);
    queue_op(ACT_PUSH,  '1, 0);
    queue_op(ACT_PUSH,  {32{2'b10}}, 1);
    queue_op(ACT_PUSH,  {32{2'b01}}, 0);
    queue_op(ACT_NOP,   {32{2'b10}}, 0);     // shows count with content held
    queue_op(ACT_POP,   '0, 0);
    queue_op(ACT_STEAL, '1, 3);
    queue_op(ACT_STEAL, '0, 0);
    queue_op(ACT_POP,   '0, 0);
    queue_op(ACT_POP,   '1, 0);              // empty again
    queue_op(ACT_STEAL, '1, 0);
    queue_op(ACT_PUSH,  {1'b1, 62'd0, 1'b1}, 0);
    queue_op(ACT_STEAL, '0, 2);
    queue_op(ACT_PUSH,  {32'hFFFF_FFFF, 32'd0}, 0);
    queue_op(ACT_PUSH,  {32'd0, 32'hFFFF_FFFF}, 0);
    queue_op(ACT_POP,   '0, 0);
    queue_op(ACT_STEAL, '0, 0);
    queue_op(ACT_NOP,   '0, 0);

    // Random: phases biased toward filling or draining, so full and empty
    // are both hit often and the positions wrap many times.
    real_ops = 0;
    while (real_ops < N_RANDOM) begin
      ph     = phase_e'($urandom_range(0, 2));
      len    = $urandom_range(40, 150);
      bursty = ($urandom_range(0, 2) == 0);
      case (ph)
        PH_FILL:  push_pct = 85;
        PH_DRAIN: push_pct = 15;
        default:  push_pct = 50;
      endcase
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          op = ACT_NOP;                       // noise
        end else if ($urandom_range(0, 99) < push_pct) begin
          op = ACT_PUSH;
        end else if ($urandom_range(0, 1) == 0) begin
          op = ACT_POP;
        end else begin
          op = ACT_STEAL;
        end
        gap = bursty ? 0 : $urandom_range(0, MAX_GAP);
        queue_op(op, rand_handle(), gap);
        if (op != ACT_NOP) real_ops++;
      end
    end

    // every request gives exactly one result
    wait (rst_ni);
    while (req_cnt < req_total || expected_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("work_stealing_task_deque_test: done, clean");
    end else begin
      $display("work_stealing_task_deque_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== work_stealing_task_deque.f =====
hdl/wsd_pkg.sv
hdl/wsd_store.sv
hdl/wsd_ctrl.sv
hdl/work_stealing_task_deque.sv
bench/work_stealing_task_deque_test.sv
